@@ rtl/qts_pkg.sv @@
package qts_pkg;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] char_out;
		logic       token_end;
		logic       unterminated;
		logic       string_done;
	} res_t;

	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} pair_t;

	function automatic res_t mk_res(input logic valid, input logic [7:0] ch,
			input logic tend, input logic unterm, input logic done);
		res_t r;
		r.byte_valid   = valid;
		r.char_out     = valid ? ch : 8'h00;
		r.token_end    = tend;
		r.unterminated = unterm;
		r.string_done  = done;
		return r;
	endfunction

endpackage

@@ rtl/qts_front.sv @@
module qts_front import qts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  char_in,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        push_valid,
	input  logic        push_ready,
	output pair_t       push_data
);

	typedef enum logic [2:0] {
		M_SKIP     = 3'd0,
		M_PLAIN    = 3'd1,
		M_QUOTED   = 3'd2,
		M_SKIP_RAW = 3'd3,
		M_RAW      = 3'd4
	} mode_t;

	mode_t       mode_q, mode_d;
	logic        bs_q, bs_d;
	logic        has_q, has_d;
	logic [15:0] cnt_q, cnt_d;
	logic [15:0] limit_q;
	logic [15:0] cnt_inc;
	mode_t       close_mode;
	res_t        r0, r1;
	logic [1:0]  n;
	logic        accept;

	assign in_ready  = push_ready;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && in_ready;

	assign cnt_inc    = (cnt_q != 16'hFFFF) ? cnt_q + 16'd1 : cnt_q;
	assign close_mode = (limit_q != 16'd0 && cnt_inc >= limit_q) ? M_SKIP_RAW : M_SKIP;

	always_comb begin
		r0     = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		r1     = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		n      = 2'd0;
		mode_d = mode_q;
		bs_d   = bs_q;
		has_d  = has_q;
		cnt_d  = cnt_q;
		if (kind == KIND_END) begin
			unique case (mode_q)
				M_PLAIN, M_RAW: begin
					r0 = mk_res(1'b0, 8'h00, 1'b1, 1'b0, 1'b1);
					n  = 2'd1;
				end
				M_QUOTED: begin
					if (bs_q) begin
						r0 = mk_res(1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0);
						r1 = mk_res(1'b0, 8'h00, has_q, has_q, 1'b1);
						n  = 2'd2;
					end else begin
						r0 = mk_res(1'b0, 8'h00, has_q, has_q, 1'b1);
						n  = 2'd1;
					end
				end
				default: begin
					r0 = mk_res(1'b0, 8'h00, 1'b0, 1'b0, 1'b1);
					n  = 2'd1;
				end
			endcase
			mode_d = M_SKIP;
			bs_d   = 1'b0;
			has_d  = 1'b0;
			cnt_d  = 16'd0;
		end else begin
			unique case (mode_q)
				M_PLAIN: begin
					if (char_in == CH_SPACE) begin
						r0     = mk_res(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
						n      = 2'd1;
						cnt_d  = cnt_inc;
						mode_d = close_mode;
						bs_d   = 1'b0;
						has_d  = 1'b0;
					end else begin
						r0 = mk_res(1'b1, char_in, 1'b0, 1'b0, 1'b0);
						n  = 2'd1;
					end
				end
				M_QUOTED: begin
					if (bs_q) begin
						if (char_in == CH_QUOTE) begin
							r0   = mk_res(1'b1, CH_QUOTE, 1'b0, 1'b0, 1'b0);
							n    = 2'd1;
							bs_d = 1'b0;
						end else if (char_in == CH_BSLASH) begin
							r0 = mk_res(1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0);
							n  = 2'd1;
						end else begin
							r0   = mk_res(1'b1, CH_BSLASH, 1'b0, 1'b0, 1'b0);
							r1   = mk_res(1'b1, char_in, 1'b0, 1'b0, 1'b0);
							n    = 2'd2;
							bs_d = 1'b0;
						end
					end else if (char_in == CH_QUOTE) begin
						r0     = mk_res(1'b0, 8'h00, 1'b1, 1'b0, 1'b0);
						n      = 2'd1;
						cnt_d  = cnt_inc;
						mode_d = close_mode;
						bs_d   = 1'b0;
						has_d  = 1'b0;
					end else if (char_in == CH_BSLASH) begin
						bs_d  = 1'b1;
						has_d = 1'b1;
					end else begin
						r0    = mk_res(1'b1, char_in, 1'b0, 1'b0, 1'b0);
						n     = 2'd1;
						has_d = 1'b1;
					end
				end
				M_SKIP_RAW: begin
					if (char_in != CH_SPACE) begin
						mode_d = M_RAW;
						r0     = mk_res(1'b1, char_in, 1'b0, 1'b0, 1'b0);
						n      = 2'd1;
					end
				end
				M_RAW: begin
					r0 = mk_res(1'b1, char_in, 1'b0, 1'b0, 1'b0);
					n  = 2'd1;
				end
				default: begin
					if (char_in == CH_QUOTE) begin
						mode_d = M_QUOTED;
						bs_d   = 1'b0;
						has_d  = 1'b0;
					end else if (char_in != CH_SPACE) begin
						mode_d = M_PLAIN;
						r0     = mk_res(1'b1, char_in, 1'b0, 1'b0, 1'b0);
						n      = 2'd1;
					end else begin
						mode_d = M_SKIP;
					end
				end
			endcase
		end
	end

	assign push_valid   = accept && (n != 2'd0);
	assign push_data.two = (n == 2'd2);
	assign push_data.r0 = r0;
	assign push_data.r1 = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_SKIP;
			bs_q    <= 1'b0;
			has_q   <= 1'b0;
			cnt_q   <= 16'd0;
			limit_q <= 16'd0;
		end else begin
			if (accept) begin
				mode_q <= mode_d;
				bs_q   <= bs_d;
				has_q  <= has_d;
				cnt_q  <= cnt_d;
			end
			if (cfg_valid && cfg_ready) begin
				limit_q <= cfg_data;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == KIND_END) |=> (mode_q == M_SKIP && cnt_q == 16'd0 && !bs_q))
		else $error("end of string left state behind");
	a_bs_in_quoted: assert property (@(posedge clk) disable iff (!arst_n)
		bs_q |-> (mode_q == M_QUOTED && has_q))
		else $error("held backslash outside a quoted token");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_ready)
		else $error("word pushed into a full queue");
`endif

endmodule

@@ rtl/qts_fifo.sv @@
module qts_fifo import qts_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  pair_t push_data,
	output logic  pop_valid,
	input  logic  pop_ready,
	output pair_t pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	pair_t           mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

@@ rtl/qts_back.sv @@
module qts_back import qts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  pair_t      pop_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       byte_valid,
	output logic [7:0] char_out,
	output logic       token_end,
	output logic       unterminated,
	output logic       string_done
);

	res_t out_q;
	logic out_valid_q;
	logic phase_q;
	logic load;

	assign load      = !out_valid_q || out_ready;
	assign pop_ready = load && (phase_q || !pop_data.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (pop_valid) begin
				phase_q <= !phase_q && pop_data.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			out_q <= phase_q ? pop_data.r1 : pop_data.r0;
		end
	end

	assign out_valid    = out_valid_q;
	assign byte_valid   = out_q.byte_valid;
	assign char_out     = out_q.char_out;
	assign token_end    = out_q.token_end;
	assign unterminated = out_q.unterminated;
	assign string_done  = out_q.string_done;

`ifndef NO_ASSERTIONS
	a_phase_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (pop_valid && pop_data.two))
		else $error("second result pending without a two-result entry");
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q && !load) |=> phase_q)
		else $error("second result dropped during a stall");
`endif

endmodule

@@ rtl/quoted_token_splitter.sv @@
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    kind, char_in
// out       output     out_valid / out_ready  byte_valid, char_out, token_end,
//                                             unterminated, string_done
// cfg       input      cfg_valid / cfg_ready  cfg_data (split_limit)
//
// one input word accepted per cycle while the queue has room
// each word yields zero, one or two results, sent one per cycle from the output register while out_ready is high
// a word with two results stays at the head of the queue until its second result is loaded into the output register
// a word's results are written into the queue, then loaded into the output register
// out_ready low fills QUEUE_DEPTH entries, then in_ready drops; cfg_ready is always high
// arst_n clears the scan state, the queue and split_limit to zero
module quoted_token_splitter import qts_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [7:0]  char_in,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        byte_valid,
	output logic [7:0]  char_out,
	output logic        token_end,
	output logic        unterminated,
	output logic        string_done
);

	logic  push_valid, push_ready;
	pair_t push_data;
	logic  pop_valid, pop_ready;
	pair_t pop_data;

	qts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.char_in    (char_in),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	qts_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	qts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_data     (pop_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_valid   (byte_valid),
		.char_out     (char_out),
		.token_end    (token_end),
		.unterminated (unterminated),
		.string_done  (string_done)
	);

endmodule
